// File: hw/rtl/pfrw_pkg.sv
// shared types, widths, register indexes and the arctangent table of the floor row warp
// no dependencies
`default_nettype none
package pfrw_pkg;

    localparam int ITER_COUNT_DEF = 16;

    // datapath widths
    localparam int VEC_W    = 44;   // vectoring x/y, normalised to [2^40, 2^41) then gain
    localparam int ZV_W     = 20;   // accumulated angle in vectoring mode
    localparam int ROT_W    = 33;   // rotation x/y, start 2^30
    localparam int ZR_W     = 19;   // residual angle in rotation mode
    localparam int DIV_BITS = 19;   // quotient bits of tan = y * 2^16 / x
    localparam int REM_W    = 50;
    localparam int DVS_W    = 32;
    localparam int T_W      = 20;

    localparam int CFG_AW   = 3;
    localparam int CFG_DW   = 32;

    // register indexes
    localparam logic [CFG_AW-1:0] REG_WARP_EN     = 3'd0;
    localparam logic [CFG_AW-1:0] REG_HORIZON     = 3'd1;
    localparam logic [CFG_AW-1:0] REG_BOTTOM      = 3'd2;
    localparam logic [CFG_AW-1:0] REG_EYE_WORLD_Y = 3'd3;
    localparam logic [CFG_AW-1:0] REG_EYE_HEIGHT  = 3'd4;
    localparam logic [CFG_AW-1:0] REG_TILT        = 3'd5;
    localparam logic [CFG_AW-1:0] REG_NDC_GAIN    = 3'd6;
    localparam logic [CFG_AW-1:0] REG_VIEW_HEIGHT = 3'd7;

    // pi/4 - 1e-3 in Q2.16
    localparam int ALPHA_CLAMP = 51406;

    typedef struct packed {
        logic        valid;
        logic        bypass;
        logic [23:0] byp_val;
    } tag_t;

    typedef struct packed {
        logic             neg;
        logic             zero;
        logic [DVS_W-1:0] dvs;
    } div_side_t;

    // atan(2^-i) in Q2.16
    function automatic logic [16:0] atan_q16(input int idx);
        logic [16:0] v;
        case (idx)
            0:       v = 17'd51472;
            1:       v = 17'd30386;
            2:       v = 17'd16055;
            3:       v = 17'd8150;
            4:       v = 17'd4091;
            5:       v = 17'd2047;
            6:       v = 17'd1024;
            7:       v = 17'd512;
            8:       v = 17'd256;
            9:       v = 17'd128;
            10:      v = 17'd64;
            11:      v = 17'd32;
            12:      v = 17'd16;
            13:      v = 17'd8;
            14:      v = 17'd4;
            15:      v = 17'd2;
            16:      v = 17'd1;
            default: v = 17'd0;
        endcase
        return v;
    endfunction

endpackage
`default_nettype wire

// File: hw/rtl/perspective_floor_row_warp_unit.sv
// perspective floor row warp: world Y of a floor point to perspective screen Y
// depends on pfrw_pkg, pfrw_vec_cell, pfrw_rot_cell, pfrw_div_cell
// throughput: one request per cycle while no result is held, every cell and stage advances together
// a stalled result holds the whole chain; s_tready = !m_tvalid || m_tready
// reset: asynchronous, clears all valid flags and loads register defaults
`default_nettype none
module perspective_floor_row_warp_unit #(
    parameter int ITER_COUNT = pfrw_pkg::ITER_COUNT_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // configuration write port
    input  logic                          cfg_we,
    input  logic [pfrw_pkg::CFG_AW-1:0]   cfg_addr,
    input  logic [pfrw_pkg::CFG_DW-1:0]   cfg_wdata,
    // request stream
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [55:0]                   s_tdata,   // [31:0] point_world_y, [55:32] flat_screen_y
    // result stream
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [23:0]                   m_tdata    // [23:0] warped_screen_y
);
    import pfrw_pkg::*;

    localparam logic signed [ROT_W-1:0] ROT_START = ROT_W'(1) << 30;
    localparam logic signed [54:0]      ONE_Q32   = 55'sd1 <<< 32;
    localparam logic signed [68:0]      HALF_RND  = 69'sd1 <<< 24;

    // configuration registers
    logic               warp_en_reg;
    logic signed [23:0] horizon_reg, bottom_reg;
    logic signed [31:0] eye_y_reg;
    logic [30:0]        eye_h_reg;
    logic signed [18:0] tilt_reg;
    logic [31:0]        gain_reg;
    logic [12:0]        vh_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            warp_en_reg <= 1'b0;
            horizon_reg <= '0;
            bottom_reg  <= '0;
            eye_y_reg   <= '0;
            eye_h_reg   <= '0;
            tilt_reg    <= '0;
            gain_reg    <= 32'd65536;
            vh_reg      <= 13'd1;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                REG_WARP_EN:     warp_en_reg <= cfg_wdata[0];
                REG_HORIZON:     horizon_reg <= cfg_wdata[23:0];
                REG_BOTTOM:      bottom_reg  <= cfg_wdata[23:0];
                REG_EYE_WORLD_Y: eye_y_reg   <= cfg_wdata[31:0];
                REG_EYE_HEIGHT:  eye_h_reg   <= cfg_wdata[30:0];
                REG_TILT:        tilt_reg    <= cfg_wdata[18:0];
                REG_NDC_GAIN:    gain_reg    <= cfg_wdata[31:0];
                REG_VIEW_HEIGHT: vh_reg      <= cfg_wdata[12:0];
                default:         ;
            endcase
        end
    end

    // global advance: the whole chain moves unless a result is held
    logic adv;
    logic o_valid_reg;
    logic [23:0] o_data_reg;

    assign adv      = !o_valid_reg || m_tready;
    assign s_tready = adv;

    // stage a: depth and the early-out decision
    logic signed [31:0] pwy;
    logic signed [23:0] fsy;
    logic signed [33:0] depth;
    tag_t               a_tag_next, a_tag_reg;
    logic [32:0]        a_d_reg;

    assign pwy   = s_tdata[31:0];
    assign fsy   = s_tdata[55:32];
    assign depth = $signed({{2{pwy[31]}}, pwy}) - $signed({{2{eye_y_reg[31]}}, eye_y_reg});

    always_comb
    begin
        a_tag_next.valid   = s_tvalid;
        a_tag_next.bypass  = !warp_en_reg || (depth <= 34'sd1);
        a_tag_next.byp_val = warp_en_reg ? horizon_reg : fsy;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            a_tag_reg <= '0;
        else if (adv)
            a_tag_reg <= a_tag_next;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            a_d_reg <= depth[32:0];
    end

    // stage b: leading-one search for the normalising shift
    logic [32:0] m_val;
    logic [5:0]  msb_pos;
    tag_t        b_tag_reg;
    logic [32:0] b_d_reg;
    logic [5:0]  b_k_reg;

    always_comb
    begin
        m_val   = (a_d_reg > {2'b00, eye_h_reg}) ? a_d_reg : {2'b00, eye_h_reg};
        msb_pos = '0;
        for (int i = 0; i < 33; i++)
        begin
            if (m_val[i])
                msb_pos = 6'(i);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            b_tag_reg <= '0;
        else if (adv)
            b_tag_reg <= a_tag_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            b_d_reg <= a_d_reg;
            b_k_reg <= 6'd40 - msb_pos;
        end
    end

    // stage c: shift depth and height together so the larger reaches 2^40
    tag_t                    c_tag_reg;
    logic signed [VEC_W-1:0] c_x_reg, c_y_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            c_tag_reg <= '0;
        else if (adv)
            c_tag_reg <= b_tag_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            c_x_reg <= $signed(VEC_W'(b_d_reg) << b_k_reg);
            c_y_reg <= $signed(VEC_W'(eye_h_reg) << b_k_reg);
        end
    end

    // atan2 chain of vectoring cells
    tag_t                    vt [0:ITER_COUNT];
    logic signed [VEC_W-1:0] vx [0:ITER_COUNT];
    logic signed [VEC_W-1:0] vy [0:ITER_COUNT];
    logic signed [ZV_W-1:0]  vz [0:ITER_COUNT];

    assign vt[0] = c_tag_reg;
    assign vx[0] = c_x_reg;
    assign vy[0] = c_y_reg;
    assign vz[0] = '0;

    for (genvar g = 0; g < ITER_COUNT; g++)
    begin : g_vec
        pfrw_vec_cell #(.STEP(g)) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .en      (adv),
            .tag_in  (vt[g]),
            .x_in    (vx[g]),
            .y_in    (vy[g]),
            .z_in    (vz[g]),
            .tag_out (vt[g+1]),
            .x_out   (vx[g+1]),
            .y_out   (vy[g+1]),
            .z_out   (vz[g+1])
        );
    end

    // alpha = tilt - phi, clamped to just inside pi/4
    logic signed [20:0]     alpha;
    logic signed [ZR_W-1:0] alpha_cl;
    tag_t                   al_tag_reg;
    logic signed [ZR_W-1:0] al_reg;

    always_comb
    begin
        alpha = $signed({{2{tilt_reg[18]}}, tilt_reg})
              - $signed({vz[ITER_COUNT][ZV_W-1], vz[ITER_COUNT]});
        if (alpha > 21'(ALPHA_CLAMP))
            alpha_cl = ZR_W'(ALPHA_CLAMP);
        else if (alpha < -21'(ALPHA_CLAMP))
            alpha_cl = -ZR_W'(ALPHA_CLAMP);
        else
            alpha_cl = alpha[ZR_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            al_tag_reg <= '0;
        else if (adv)
            al_tag_reg <= vt[ITER_COUNT];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            al_reg <= alpha_cl;
    end

    // tangent chain of rotation cells
    tag_t                    rt [0:ITER_COUNT];
    logic signed [ROT_W-1:0] rx [0:ITER_COUNT];
    logic signed [ROT_W-1:0] ry [0:ITER_COUNT];
    logic signed [ZR_W-1:0]  rz [0:ITER_COUNT];

    assign rt[0] = al_tag_reg;
    assign rx[0] = ROT_START;
    assign ry[0] = '0;
    assign rz[0] = al_reg;

    for (genvar g = 0; g < ITER_COUNT; g++)
    begin : g_rot
        pfrw_rot_cell #(.STEP(g)) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .en      (adv),
            .tag_in  (rt[g]),
            .x_in    (rx[g]),
            .y_in    (ry[g]),
            .z_in    (rz[g]),
            .tag_out (rt[g+1]),
            .x_out   (rx[g+1]),
            .y_out   (ry[g+1]),
            .z_out   (rz[g+1])
        );
    end

    // divider set-up: magnitude of y scaled by 2^16, sign kept aside
    logic signed [ROT_W-1:0] y_fin, x_fin;
    logic [ROT_W-1:0]        y_mag;
    tag_t                    dp_tag_reg;
    div_side_t               dp_side_reg;
    logic [REM_W-1:0]        dp_rem_reg;

    assign y_fin = ry[ITER_COUNT];
    assign x_fin = rx[ITER_COUNT];
    assign y_mag = (y_fin < 0) ? ROT_W'(-y_fin) : ROT_W'(y_fin);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            dp_tag_reg <= '0;
        else if (adv)
            dp_tag_reg <= rt[ITER_COUNT];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            dp_side_reg.neg  <= (y_fin < 0);
            dp_side_reg.zero <= (x_fin <= 0);
            dp_side_reg.dvs  <= x_fin[DVS_W-1:0];
            dp_rem_reg       <= REM_W'(y_mag) << 16;
        end
    end

    // quotient chain, most significant bit first
    tag_t                dt [0:DIV_BITS];
    div_side_t           ds [0:DIV_BITS];
    logic [REM_W-1:0]    dr [0:DIV_BITS];
    logic [DIV_BITS-1:0] dq [0:DIV_BITS];

    assign dt[0] = dp_tag_reg;
    assign ds[0] = dp_side_reg;
    assign dr[0] = dp_rem_reg;
    assign dq[0] = '0;

    for (genvar g = 0; g < DIV_BITS; g++)
    begin : g_div
        pfrw_div_cell #(.BIT(DIV_BITS - 1 - g)) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .en       (adv),
            .tag_in   (dt[g]),
            .side_in  (ds[g]),
            .rem_in   (dr[g]),
            .q_in     (dq[g]),
            .tag_out  (dt[g+1]),
            .side_out (ds[g+1]),
            .rem_out  (dr[g+1]),
            .q_out    (dq[g+1])
        );
    end

    // signed tangent, truncated toward zero, zero when x is not positive
    logic signed [T_W-1:0] t_mag;
    tag_t                  t_tag_reg;
    logic signed [T_W-1:0] t_reg;

    assign t_mag = $signed({1'b0, dq[DIV_BITS]});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            t_tag_reg <= '0;
        else if (adv)
            t_tag_reg <= dt[DIV_BITS];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            if (ds[DIV_BITS].zero)
                t_reg <= '0;
            else if (ds[DIV_BITS].neg)
                t_reg <= -t_mag;
            else
                t_reg <= t_mag;
        end
    end

    // ndc = tan * gain, Q.32
    tag_t               n_tag_reg;
    logic signed [52:0] ndc_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            n_tag_reg <= '0;
        else if (adv)
            n_tag_reg <= t_tag_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            ndc_reg <= 53'(t_reg * $signed({1'b0, gain_reg}));
    end

    // v = (1.0 - ndc) * view_height
    logic signed [54:0] one_minus;
    tag_t               v_tag_reg;
    logic signed [68:0] v_reg;

    assign one_minus = ONE_Q32 - $signed({{2{ndc_reg[52]}}, ndc_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_tag_reg <= '0;
        else if (adv)
            v_tag_reg <= n_tag_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            v_reg <= 69'(one_minus * $signed({1'b0, vh_reg}));
    end

    // round half up to Q.7, then clamp between horizon and bottom
    logic signed [68:0] v_rnd;
    logic signed [43:0] y_raw, hz_x, bt_x;
    logic [23:0]        y_cl, res_data;

    always_comb
    begin
        v_rnd = v_reg + HALF_RND;
        y_raw = v_rnd[68:25];
        hz_x  = $signed({{20{horizon_reg[23]}}, horizon_reg});
        bt_x  = $signed({{20{bottom_reg[23]}}, bottom_reg});
        if (y_raw < hz_x)
            y_cl = horizon_reg;
        else if (y_raw > bt_x)
            y_cl = bottom_reg;
        else
            y_cl = y_raw[23:0];
        res_data = v_tag_reg.bypass ? v_tag_reg.byp_val : y_cl;
    end

    // output register parts the chain from the result side
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            o_valid_reg <= 1'b0;
        else if (adv)
            o_valid_reg <= v_tag_reg.valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            o_data_reg <= res_data;
    end

    assign m_tvalid = o_valid_reg;
    assign m_tdata  = o_data_reg;
endmodule
`default_nettype wire

// File: hw/rtl/pfrw_vec_cell.sv
// one vectoring micro-rotation of the atan2 chain
// depends on pfrw_pkg
`default_nettype none
module pfrw_vec_cell #(
    parameter int STEP = 0
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              en,
    input  pfrw_pkg::tag_t                    tag_in,
    input  logic signed [pfrw_pkg::VEC_W-1:0] x_in,
    input  logic signed [pfrw_pkg::VEC_W-1:0] y_in,
    input  logic signed [pfrw_pkg::ZV_W-1:0]  z_in,
    output pfrw_pkg::tag_t                    tag_out,
    output logic signed [pfrw_pkg::VEC_W-1:0] x_out,
    output logic signed [pfrw_pkg::VEC_W-1:0] y_out,
    output logic signed [pfrw_pkg::ZV_W-1:0]  z_out
);
    import pfrw_pkg::*;

    logic signed [VEC_W-1:0] xs, ys, x_next, y_next;
    logic signed [ZV_W-1:0]  step_ang, z_next;
    tag_t                    tag_reg;
    logic signed [VEC_W-1:0] x_reg, y_reg;
    logic signed [ZV_W-1:0]  z_reg;

    assign step_ang = $signed({{(ZV_W-17){1'b0}}, atan_q16(STEP)});

    always_comb
    begin
        xs = x_in >>> STEP;
        ys = y_in >>> STEP;
        if (y_in > 0)
        begin
            x_next = x_in + ys;
            y_next = y_in - xs;
            z_next = z_in + step_ang;
        end
        else
        begin
            x_next = x_in - ys;
            y_next = y_in + xs;
            z_next = z_in - step_ang;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            tag_reg <= '0;
        else if (en)
            tag_reg <= tag_in;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg <= x_next;
            y_reg <= y_next;
            z_reg <= z_next;
        end
    end

    assign tag_out = tag_reg;
    assign x_out   = x_reg;
    assign y_out   = y_reg;
    assign z_out   = z_reg;
endmodule
`default_nettype wire

// File: hw/rtl/pfrw_rot_cell.sv
// one rotation-mode micro-rotation of the tangent chain
// depends on pfrw_pkg
`default_nettype none
module pfrw_rot_cell #(
    parameter int STEP = 0
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              en,
    input  pfrw_pkg::tag_t                    tag_in,
    input  logic signed [pfrw_pkg::ROT_W-1:0] x_in,
    input  logic signed [pfrw_pkg::ROT_W-1:0] y_in,
    input  logic signed [pfrw_pkg::ZR_W-1:0]  z_in,
    output pfrw_pkg::tag_t                    tag_out,
    output logic signed [pfrw_pkg::ROT_W-1:0] x_out,
    output logic signed [pfrw_pkg::ROT_W-1:0] y_out,
    output logic signed [pfrw_pkg::ZR_W-1:0]  z_out
);
    import pfrw_pkg::*;

    logic signed [ROT_W-1:0] xs, ys, x_next, y_next;
    logic signed [ZR_W-1:0]  step_ang, z_next;
    tag_t                    tag_reg;
    logic signed [ROT_W-1:0] x_reg, y_reg;
    logic signed [ZR_W-1:0]  z_reg;

    assign step_ang = $signed({{(ZR_W-17){1'b0}}, atan_q16(STEP)});

    always_comb
    begin
        xs = x_in >>> STEP;
        ys = y_in >>> STEP;
        if (z_in >= 0)
        begin
            x_next = x_in - ys;
            y_next = y_in + xs;
            z_next = z_in - step_ang;
        end
        else
        begin
            x_next = x_in + ys;
            y_next = y_in - xs;
            z_next = z_in + step_ang;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            tag_reg <= '0;
        else if (en)
            tag_reg <= tag_in;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg <= x_next;
            y_reg <= y_next;
            z_reg <= z_next;
        end
    end

    assign tag_out = tag_reg;
    assign x_out   = x_reg;
    assign y_out   = y_reg;
    assign z_out   = z_reg;
endmodule
`default_nettype wire

// File: hw/rtl/pfrw_div_cell.sv
// one restoring-division step, settles one quotient bit
// depends on pfrw_pkg
`default_nettype none
module pfrw_div_cell #(
    parameter int BIT = 0
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             en,
    input  pfrw_pkg::tag_t                   tag_in,
    input  pfrw_pkg::div_side_t              side_in,
    input  logic [pfrw_pkg::REM_W-1:0]       rem_in,
    input  logic [pfrw_pkg::DIV_BITS-1:0]    q_in,
    output pfrw_pkg::tag_t                   tag_out,
    output pfrw_pkg::div_side_t              side_out,
    output logic [pfrw_pkg::REM_W-1:0]       rem_out,
    output logic [pfrw_pkg::DIV_BITS-1:0]    q_out
);
    import pfrw_pkg::*;

    logic [REM_W-1:0]    dshift, rem_next;
    logic [DIV_BITS-1:0] q_next;
    tag_t                tag_reg;
    div_side_t           side_reg;
    logic [REM_W-1:0]    rem_reg;
    logic [DIV_BITS-1:0] q_reg;

    always_comb
    begin
        dshift = REM_W'(side_in.dvs) << BIT;
        if (rem_in >= dshift)
        begin
            rem_next = rem_in - dshift;
            q_next   = q_in | (DIV_BITS'(1) << BIT);
        end
        else
        begin
            rem_next = rem_in;
            q_next   = q_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            tag_reg <= '0;
        else if (en)
            tag_reg <= tag_in;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_reg <= side_in;
            rem_reg  <= rem_next;
            q_reg    <= q_next;
        end
    end

    assign tag_out  = tag_reg;
    assign side_out = side_reg;
    assign rem_out  = rem_reg;
    assign q_out    = q_reg;
endmodule
`default_nettype wire

// File: hw/rtl/pfrw_checker.sv
// port-level checks of the floor row warp stream behaviour
// depends on nothing; bound to perspective_floor_row_warp_unit
`default_nettype none
module pfrw_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata
);
    // a held result keeps its value
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // the chain only stalls when a result is waiting
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        s_tready == (!m_tvalid || m_tready))
        else $error("ready does not follow result side");

    // no result straight out of reset
    a_rst: assert property (@(posedge clk)
        !rst_n |=> !m_tvalid)
        else $error("result valid after reset");

    // nothing pops out of an empty chain at a reset release
    a_first: assert property (@(posedge clk)
        $rose(rst_n) |-> !m_tvalid)
        else $error("result valid at reset release");
endmodule

bind perspective_floor_row_warp_unit pfrw_checker u_pfrw_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
`default_nettype wire
